// ===== design/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_BITS  = 12;
  localparam int PAGE_BYTES = 1 << PAGE_BITS;

  localparam int ADDR_W = 24;
  localparam int AMT_W  = 25;
  localparam int CNT_W  = $clog2(MAX_PAGES) + 1;   // page count, 0..MAX_PAGES
  localparam int PG_W   = $clog2(MAX_PAGES);       // page index
  localparam int NEED_W = AMT_W - PAGE_BITS + 1;   // rounded-up page request

  // bitmap word geometry
  localparam int WORD_W  = 16;
  localparam int WB_W    = $clog2(WORD_W);
  localparam int N_WORDS = MAX_PAGES / WORD_W;
  localparam int WIDX_W  = $clog2(N_WORDS);
  localparam int PC_W    = WB_W + 1;

  localparam int S_DATA_W = 56;  // 2 + 24 + 25 bits, padded to bytes
  localparam int M_DATA_W = 40;  // 24 + 1 + 13 bits, padded to bytes

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DEC   = 7'b0000010,
    ST_COUNT = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_SETRD = 7'b0010000,
    ST_SETWR = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

endpackage

// ===== design/bitmap_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit physical page allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
// One request at a time; the bitmap sits in a 256 x 16 bit memory with one
// read and one write port, so every sequence walks 16 pages per memory word.
// A request that ends at decode or does nothing goes from decode straight to
// the result; free and mark read and write back each word touched. Allocate
// scans one word at a time from page zero, at most ceil(managed/16) words and
// at least one, then reads and writes back each word of the claimed run.
// A write of managed_pages starts a recount of the free pages over each
// managed word (at least one), during which no request is taken.
// A result still waiting on the output holds the next one back.
// All pages read as used after reset.
module bitmap_page_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: managed_pages
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bpa_pkg::CNT_W-1:0]    cfg_data_i,
  // requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] cmd, [25:2] byte_address, [50:26] byte_amount
  input  logic [bpa_pkg::S_DATA_W-1:0] s_axis_tdata,
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [23:0] alloc_address, [24] alloc_ok, [37:25] free_pages
  output logic [bpa_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import bpa_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  m_q, m_d;          // managed pages, clamped
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;    // free page count
  logic [N_WORDS-1:0] vld_q;            // word written since reset

  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [WIDX_W-1:0] pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [PG_W-1:0]   start_q, start_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [PG_W-1:0]   first_q, first_d;
  logic [CNT_W-1:0]  end_q, end_d;
  logic              used_q, used_d;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] aaddr_q, aaddr_d;

  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] baddr_q, baddr_d;
  logic [AMT_W-1:0]  amt_q, amt_d;

  logic                out_vld_q, out_vld_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;

  // bitmap memory
  logic [WORD_W-1:0] mem [N_WORDS];
  logic [WORD_W-1:0] rd_q;
  logic              rvld_q;
  logic              mem_re, mem_we;
  logic [WIDX_W-1:0] raddr;
  logic [WORD_W-1:0] wdata;

  logic [WORD_W-1:0] rdat;
  logic [WORD_W-1:0] freeb;
  logic [PC_W-1:0]   free_pc;
  logic [PG_W-1:0]   base;

  // scan datapath
  logic              hit;
  logic [PG_W-1:0]   hit_start;
  logic [CNT_W-1:0]  scan_run_n;
  logic [PG_W-1:0]   scan_start_n;
  logic [PG_W-1:0]   start_eff;
  logic              scan_last;

  // set-range datapath
  logic [WORD_W-1:0] smask;
  logic [WORD_W-1:0] new_word;
  logic [PC_W-1:0]   chg_pc;
  logic              set_last;

  // decode
  logic [AMT_W:0]    amt_sum;
  logic [NEED_W-1:0] npages;
  logic [PG_W-1:0]   dec_first;
  logic [NEED_W-1:0] end_raw;

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign rdat = rvld_q ? rd_q : '1;
  assign base = {pidx_q, {WB_W{1'b0}}};

  // free bits of the word in hand, pages past the managed range count as used
  always_comb begin
    logic [PG_W-1:0] pg;
    freeb   = '0;
    free_pc = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pg       = {pidx_q, WB_W'(i)};
      freeb[i] = !rdat[i] && ({1'b0, pg} < m_q);
      free_pc  = free_pc + PC_W'(freeb[i]);
    end
  end

  // first-fit step over one word: runs ending at each bit, lowest hit wins
  always_comb begin
    logic [PC_W-1:0]  z [WORD_W];
    logic             pre [WORD_W];
    logic [CNT_W-1:0] run_i;
    logic             all_free;
    start_eff = (run_q == '0) ? base : start_q;
    hit       = 1'b0;
    hit_start = '0;
    all_free  = &freeb;
    for (int i = 0; i < WORD_W; i++) begin
      z[i]   = '0;
      pre[i] = 1'b1;
      for (int j = 0; j <= i; j++) begin
        if (!freeb[j]) begin
          z[i] = PC_W'(j + 1);
        end
        pre[i] = pre[i] & freeb[j];
      end
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      run_i = pre[i] ? run_q + CNT_W'(i + 1) : CNT_W'(i + 1) - CNT_W'(z[i]);
      if (freeb[i] && ({1'b0, run_i} >= need_q)) begin
        hit       = 1'b1;
        hit_start = pre[i] ? start_eff : base + PG_W'(z[i]);
      end
    end
    if (all_free) begin
      scan_run_n   = run_q + CNT_W'(WORD_W);
      scan_start_n = start_eff;
    end else begin
      scan_run_n   = CNT_W'(WORD_W) - CNT_W'(z[WORD_W-1]);
      scan_start_n = base + PG_W'(z[WORD_W-1]);
    end
    scan_last = ({1'b0, base} + CNT_W'(WORD_W)) >= m_q;
  end

  // read-modify-write of one word for free / mark and for an allocated run
  always_comb begin
    logic [PG_W-1:0] pg;
    smask  = '0;
    chg_pc = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pg       = {widx_q, WB_W'(i)};
      smask[i] = (pg >= first_q) && ({1'b0, pg} < end_q);
    end
    new_word = used_q ? (rdat | smask) : (rdat & ~smask);
    for (int i = 0; i < WORD_W; i++) begin
      chg_pc = chg_pc + PC_W'(rdat[i] ^ new_word[i]);
    end
    set_last = ({1'b0, widx_q, {WB_W{1'b0}}} + CNT_W'(WORD_W)) >= end_q;
  end

  assign amt_sum   = {1'b0, amt_q} + (AMT_W + 1)'(PAGE_BYTES - 1);
  assign npages    = amt_sum[AMT_W:PAGE_BITS];
  assign dec_first = baddr_q[ADDR_W-1:PAGE_BITS];
  assign end_raw   = NEED_W'(dec_first) + npages;

  always_comb begin
    state_d    = state_q;
    m_d        = m_q;
    fcnt_d     = fcnt_q;
    widx_d     = widx_q;
    pidx_d     = pidx_q;
    pend_d     = pend_q;
    run_d      = run_q;
    start_d    = start_q;
    need_d     = need_q;
    first_d    = first_q;
    end_d      = end_q;
    used_d     = used_q;
    ok_d       = ok_q;
    aaddr_d    = aaddr_q;
    cmd_d      = cmd_q;
    baddr_d    = baddr_q;
    amt_d      = amt_q;
    out_vld_d  = out_vld_q & ~m_axis_tready;
    out_data_d = out_data_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    raddr      = widx_q;
    wdata      = new_word;

    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          m_d     = (cfg_data_i > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_data_i;
          fcnt_d  = '0;
          widx_d  = '0;
          pend_d  = 1'b0;
          state_d = ST_COUNT;
        end else if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tdata[1:0]);
          baddr_d = s_axis_tdata[2 +: ADDR_W];
          amt_d   = s_axis_tdata[2 + ADDR_W +: AMT_W];
          state_d = ST_DEC;
        end
      end

      ST_DEC: begin
        ok_d    = 1'b0;
        aaddr_d = '0;
        case (cmd_q)
          CMD_ALLOC: begin
            if (npages == '0) begin
              state_d = ST_FIN;
            end else begin
              need_d  = npages;
              widx_d  = '0;
              pend_d  = 1'b0;
              run_d   = '0;
              state_d = ST_SCAN;
            end
          end
          CMD_FREE, CMD_MARK: begin
            used_d = (cmd_q == CMD_MARK);
            if (({1'b0, dec_first} >= m_q) || (npages == '0)) begin
              state_d = ST_FIN;
            end else begin
              first_d = dec_first;
              end_d   = (end_raw > NEED_W'(m_q)) ? m_q : end_raw[CNT_W-1:0];
              widx_d  = dec_first[PG_W-1:WB_W];
              state_d = ST_SETRD;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end

      ST_COUNT: begin
        mem_re = 1'b1;
        widx_d = widx_q + 1'b1;
        pidx_d = widx_q;
        pend_d = 1'b1;
        if (pend_q) begin
          fcnt_d = fcnt_q + CNT_W'(free_pc);
          if (scan_last) begin
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        mem_re = 1'b1;
        widx_d = widx_q + 1'b1;
        pidx_d = widx_q;
        pend_d = 1'b1;
        if (pend_q) begin
          if (hit) begin
            first_d = hit_start;
            end_d   = {1'b0, hit_start} + need_q[CNT_W-1:0];
            used_d  = 1'b1;
            ok_d    = 1'b1;
            aaddr_d = ADDR_W'({hit_start, {PAGE_BITS{1'b0}}});
            widx_d  = hit_start[PG_W-1:WB_W];
            pend_d  = 1'b0;
            state_d = ST_SETRD;
          end else begin
            run_d   = scan_run_n;
            start_d = scan_start_n;
            if (scan_last) begin
              pend_d  = 1'b0;
              state_d = ST_FIN;
            end
          end
        end
      end

      ST_SETRD: begin
        mem_re  = 1'b1;
        state_d = ST_SETWR;
      end

      ST_SETWR: begin
        mem_we = 1'b1;
        fcnt_d = used_q ? fcnt_q - CNT_W'(chg_pc) : fcnt_q + CNT_W'(chg_pc);
        if (set_last) begin
          state_d = ST_FIN;
        end else begin
          widx_d  = widx_q + 1'b1;
          state_d = ST_SETRD;
        end
      end

      ST_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {{(M_DATA_W - ADDR_W - 1 - CNT_W){1'b0}}, fcnt_d, ok_q, aaddr_q};
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // bitmap storage, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[widx_q] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[widx_q] <= 1'b1;
      end
      if (mem_re) begin
        rvld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_q       <= CNT_W'(MAX_PAGES);
      fcnt_q    <= '0;
      widx_q    <= '0;
      pidx_q    <= '0;
      pend_q    <= 1'b0;
      run_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_q       <= m_d;
      fcnt_q    <= fcnt_d;
      widx_q    <= widx_d;
      pidx_q    <= pidx_d;
      pend_q    <= pend_d;
      run_q     <= run_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    need_q     <= need_d;
    first_q    <= first_d;
    end_q      <= end_d;
    used_q     <= used_d;
    ok_q       <= ok_d;
    aaddr_q    <= aaddr_d;
    cmd_q      <= cmd_d;
    baddr_q    <= baddr_d;
    amt_q      <= amt_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== test/bpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// Watches the config, request and result channels of the page allocator,
// keeps its own bitmap and free count, and compares every result in order.
// ----------------------------------------------------------------------------
module bpa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // [1:0] cmd, [25:2] byte_address, [50:26] byte_amount
  input  logic [bpa_pkg::S_DATA_W-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // [23:0] alloc_address, [24] alloc_ok, [37:25] free_pages
  input  logic [bpa_pkg::M_DATA_W-1:0]  m_tdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
    logic [CNT_W-1:0]  free_pages;
  } reply_t;

  bit          page_taken [MAX_PAGES];
  int unsigned free_tally;
  int unsigned managed_limit;
  int unsigned mismatches;
  reply_t      replies_due [$];

  function automatic int unsigned live_pages();
    return (managed_limit > MAX_PAGES) ? MAX_PAGES : managed_limit;
  endfunction

  function automatic int unsigned pages_of(logic [AMT_W-1:0] bytes);
    return (32'(bytes) + PAGE_BYTES - 1) >> PAGE_BITS;
  endfunction

  function automatic void recount_free();
    free_tally = 0;
    for (int unsigned i = 0; i < live_pages(); i++)
      if (!page_taken[i]) free_tally++;
  endfunction

  // set or clear a page range, clipped to the managed pages
  function automatic void paint(int unsigned first, int unsigned count, bit used);
    int unsigned lim;
    int unsigned stop;
    lim = live_pages();
    if (first >= lim) return;
    stop = (count > lim - first) ? lim : first + count;
    for (int unsigned p = first; p < stop; p++) begin
      if (page_taken[p] != used) begin
        page_taken[p] = used;
        if (used) free_tally--;
        else free_tally++;
      end
    end
  endfunction

  function automatic reply_t serve_request(cmd_e cmd, logic [ADDR_W-1:0] addr,
                                           logic [AMT_W-1:0] amount);
    reply_t      r;
    int unsigned need;
    int unsigned run;
    int unsigned first;
    r     = '0;
    run   = 0;
    first = 0;
    case (cmd)
      CMD_ALLOC: begin
        need = pages_of(amount);
        // first fit from page zero
        if (need != 0) begin
          for (int unsigned i = 0; i < live_pages() && !r.ok; i++) begin
            if (!page_taken[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == need) begin
                paint(first, need, 1'b1);
                r.addr = ADDR_W'(first * PAGE_BYTES);
                r.ok   = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      CMD_FREE: paint(32'(addr) >> PAGE_BITS, pages_of(amount), 1'b0);
      CMD_MARK: paint(32'(addr) >> PAGE_BITS, pages_of(amount), 1'b1);
      default: ;
    endcase
    r.free_pages = CNT_W'(free_tally);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t seen;
    reply_t due;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PAGES; i++) page_taken[i] = 1'b1;
      free_tally    = 0;
      managed_limit = MAX_PAGES;
      mismatches    = 0;
      replies_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        managed_limit = cfg_data_i;
        recount_free();
      end
      if (s_tvalid_i && s_tready_i)
        replies_due.push_back(serve_request(cmd_e'(s_tdata_i[1:0]), s_tdata_i[25:2],
                                            s_tdata_i[50:26]));
      if (m_tvalid_i && m_tready_i) begin
        seen.addr       = m_tdata_i[23:0];
        seen.ok         = m_tdata_i[24];
        seen.free_pages = m_tdata_i[37:25];
        if (replies_due.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, got %h",
                   $time, m_tdata_i);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (seen.addr !== due.addr) begin
            $display("%0t: alloc_address expected %h got %h", $time, due.addr, seen.addr);
            mismatches++;
          end
          if (seen.ok !== due.ok) begin
            $display("%0t: alloc_ok expected %b got %b", $time, due.ok, seen.ok);
            mismatches++;
          end
          if (seen.free_pages !== due.free_pages) begin
            $display("%0t: free_pages expected %0d got %0d", $time, due.free_pages,
                     seen.free_pages);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= replies_due.size();
  end

endmodule

// ===== test/tb_bitmap_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_unit
// Drives allocate, free and mark requests plus managed-page settings into the
// allocator with random idle gaps on both sides; bpa_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator_unit;
  import bpa_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cmd_tally [4];
  int unsigned settings;
  bit          send_burst;
  bit          take_burst;

  bitmap_page_allocator_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bpa_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // worst case is far below this: full scans plus full marks on every request
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic push_request(cmd_e cmd, logic [ADDR_W-1:0] addr,
                              logic [AMT_W-1:0] amount);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({amount, addr, cmd});
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_tally[cmd]++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // mostly in-range pages and short runs so the bitmap fragments; some noise
  task automatic random_request(int unsigned span);
    cmd_e        cmd;
    int unsigned r;
    int unsigned pages;
    int unsigned page;
    logic [ADDR_W-1:0] addr;
    logic [AMT_W-1:0]  amount;
    r = $urandom_range(0, 99);
    if (r < 40) cmd = CMD_ALLOC;
    else if (r < 73) cmd = CMD_FREE;
    else if (r < 94) cmd = CMD_MARK;
    else cmd = CMD_NOP;

    r = $urandom_range(0, 99);
    if (r < 70) begin
      page = $urandom_range(0, span - 1);
      addr = {page[11:0], ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'h000};
    end else if (r < 85) begin
      page = $urandom_range(0, (span + 32 > 4095) ? 4095 : span + 32);
      addr = {page[11:0], 12'($urandom)};
    end else begin
      addr = ADDR_W'($urandom);
    end

    r = $urandom_range(0, 99);
    if (r < 76) begin
      case (cmd)
        CMD_ALLOC: pages = $urandom_range(1, 12);
        CMD_FREE:  pages = $urandom_range(1, 40);
        default:   pages = $urandom_range(1, 8);
      endcase
      amount = AMT_W'(pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
    end else if (r < 86) begin
      amount = AMT_W'($urandom_range(0, 1 << 24));
    end else if (r < 90) begin
      amount = '0;
    end else if (r < 94) begin
      amount = AMT_W'(1 << 24);
    end else begin
      amount = AMT_W'($urandom_range(0, span) * PAGE_BYTES);
    end
    push_request(cmd, addr, amount);
  endtask

  // result side: random stall before each result, with stall-free stretches
  initial begin : sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int unsigned limits [8];
    int unsigned counts [8];
    int unsigned span;
    limits = '{16, 0, 8191, 300, 4096, 1, 4095, $urandom_range(17, 2000)};
    counts = '{260, 40, 270, 260, 260, 160, 270, 260};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, field extremes, clipping, exact fits
    push_request(CMD_NOP,   24'h000000, 25'h0000000);
    push_request(CMD_ALLOC, 24'h000000, 25'h0000001);  // nothing free yet
    push_request(CMD_FREE,  24'h000000, 25'h0000000);  // zero pages
    push_request(CMD_FREE,  24'h000000, 25'h1000000);  // free everything
    push_request(CMD_ALLOC, 24'hFFFFFF, 25'h0000000);  // zero-page allocate
    push_request(CMD_ALLOC, 24'h000000, 25'h0000001);  // lands at page zero
    push_request(CMD_ALLOC, 24'h000000, 25'h0001000);
    push_request(CMD_ALLOC, 24'h000000, 25'h0001001);  // rounds up to two pages
    push_request(CMD_FREE,  24'h001FFF, 25'h0000001);
    push_request(CMD_ALLOC, 24'h000000, 25'h0001000);  // reuses the freed hole
    push_request(CMD_ALLOC, 24'h000000, 25'h1000000);  // no room
    push_request(CMD_MARK,  24'hFFFFFF, 25'h1000000);  // clipped at the top
    push_request(CMD_ALLOC, 24'h000000, 25'h0FFFFFF);
    push_request(CMD_FREE,  24'hFFF000, 25'h0000001);
    push_request(CMD_MARK,  24'h000000, 25'h1000000);  // everything used
    push_request(CMD_ALLOC, 24'h000000, 25'h0000001);
    push_request(CMD_FREE,  24'h800000, 25'h0800000);
    push_request(CMD_ALLOC, 24'h000000, 25'h0800000);  // exact fit, upper half
    push_request(CMD_FREE,  24'hAAAAAA, 25'h0155555);
    push_request(CMD_ALLOC, 24'h555555, 25'h0155555);
    push_request(CMD_FREE,  24'h555555, 25'h0AAAAAA);
    push_request(CMD_MARK,  24'h123456, 25'h0054321);
    push_request(CMD_NOP,   24'hFFFFFF, 25'h1000000);
    push_request(CMD_ALLOC, 24'h000000, 25'h0001000);

    foreach (limits[k]) begin
      write_limit(CNT_W'(limits[k]));
      span = (limits[k] == 0) ? 16 : (limits[k] > MAX_PAGES ? MAX_PAGES : limits[k]);
      repeat (counts[k]) random_request(span);
    end

    drain();
    repeat (32) @(posedge clk_i);
    $display("run: %0d requests: %0d allocate, %0d free, %0d mark, %0d unused command",
             cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
    $display("run: %0d managed-page writes, from 0 up to 8191, with random stalls",
             settings);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
